>>> rtl/core/cbm_pkg.sv
// Shared types, codes and constants of the CSMA backoff MAC controller.
`default_nettype none

package cbm_pkg;

  localparam int ADDR_W     = 8;
  localparam int DRAW_W     = 10;
  localparam int SLOT_W     = 16;
  localparam int PROD_W     = DRAW_W + SLOT_W;
  localparam int OPCODE_W   = 3;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SLOT_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam int BACKOFF_BITS_DEF = 26;

  localparam logic [ADDR_W-1:0] BCAST_ADDR    = 8'hFF;
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST  = 8'd0;
  localparam logic [DRAW_W-1:0] CW_RST        = 10'd10;
  localparam logic [SLOT_W-1:0] SLOT_RST      = 16'd20;

  // Event opcodes
  localparam logic [OPCODE_W-1:0] OP_SEND  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CHAN  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TXEND = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RXHDR = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT     = 2'd2;

  // Reported state codes
  localparam logic [CODE_W-1:0] CODE_IDLE    = 2'd0;
  localparam logic [CODE_W-1:0] CODE_CCABUSY = 2'd1;
  localparam logic [CODE_W-1:0] CODE_RUNNING = 2'd2;
  localparam logic [CODE_W-1:0] CODE_TX      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CCABUSY = 4'b0010,
    ST_RUNNING = 4'b0100,
    ST_TX      = 4'b1000
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   dest_address;
    logic                phy_busy;
    logic                phy_cca_busy;
    logic                phy_idle;
    logic                channel_busy;
    logic [DRAW_W-1:0]   backoff_draw;
    logic [ADDR_W-1:0]   rx_dest;
    logic [ADDR_W-1:0]   rx_src;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              send_now;
    logic [ADDR_W-1:0] send_dest;
    logic              forward_up;
    logic [ADDR_W-1:0] forward_src;
    logic [CODE_W-1:0] mac_state;
    logic              bad_tx_end;
  } result_t;

  function automatic logic [CODE_W-1:0] state_code(state_e st);
    logic [CODE_W-1:0] code;
    case (st)
      ST_IDLE:    code = CODE_IDLE;
      ST_CCABUSY: code = CODE_CCABUSY;
      ST_RUNNING: code = CODE_RUNNING;
      ST_TX:      code = CODE_TX;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cbm_in_reg.sv
// Input register: unpacks and holds one event until the core takes it.
`default_nettype none

module cbm_in_reg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [cbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [cbm_pkg::OPCODE_W-1:0]   s_axis_tuser,
  input  wire logic                           adv_i,
  output logic                                item_vld_o,
  output cbm_pkg::item_t                      item_o
);
  import cbm_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  take;

  assign s_axis_tready = !vld_q || adv_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d                = take ? 1'b1 : (adv_i ? 1'b0 : vld_q);
    item_d               = item_q;
    if (take) begin
      item_d.opcode       = s_axis_tuser;
      item_d.dest_address = s_axis_tdata[7:0];
      item_d.phy_busy     = s_axis_tdata[8];
      item_d.phy_cca_busy = s_axis_tdata[9];
      item_d.phy_idle     = s_axis_tdata[10];
      item_d.channel_busy = s_axis_tdata[11];
      item_d.backoff_draw = s_axis_tdata[21:12];
      item_d.rx_dest      = s_axis_tdata[29:22];
      item_d.rx_src       = s_axis_tdata[37:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

`default_nettype wire

>>> rtl/core/cbm_core.sv
// Controller state, configuration registers and the per-event update logic.
`default_nettype none

module cbm_core #(
  parameter int BACKOFF_BITS = cbm_pkg::BACKOFF_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            adv_i,
  input  wire cbm_pkg::item_t                  item_i,
  output cbm_pkg::result_t                     res_o
);
  import cbm_pkg::*;

  localparam int EXT_W = (BACKOFF_BITS > PROD_W) ? BACKOFF_BITS : PROD_W;
  localparam logic [EXT_W-1:0] LIMIT = EXT_W'({BACKOFF_BITS{1'b1}});

  logic [ADDR_W-1:0]       own_q;
  logic [DRAW_W-1:0]       cw_q;
  logic [SLOT_W-1:0]       slot_q;

  state_e                  state_q, state_d;
  logic [BACKOFF_BITS-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0]       pend_q, pend_d;

  logic [DRAW_W-1:0]       draw_c;
  logic [PROD_W-1:0]       prod_c;
  logic [EXT_W-1:0]        prod_ext;
  logic [BACKOFF_BITS-1:0] load_c;
  logic [BACKOFF_BITS-1:0] rem_tick;
  logic [BACKOFF_BITS-1:0] start_rem;
  logic                    start;
  result_t                 res;

  // Clamp the draw below the window (to zero when the window is zero)
  always_comb begin
    draw_c = item_i.backoff_draw;
    if (cw_q == '0) begin
      draw_c = '0;
    end else if (draw_c >= cw_q) begin
      draw_c = cw_q - 1'b1;
    end
  end

  assign prod_c   = {{SLOT_W{1'b0}}, draw_c} * {{DRAW_W{1'b0}}, slot_q};
  assign prod_ext = EXT_W'(prod_c);
  assign load_c   = (prod_ext > LIMIT) ? {BACKOFF_BITS{1'b1}} : BACKOFF_BITS'(prod_ext);
  assign rem_tick = (rem_q == '0) ? rem_q : rem_q - 1'b1;

  always_comb begin
    res       = '0;
    state_d   = state_q;
    rem_d     = rem_q;
    pend_d    = pend_q;
    start     = 1'b0;
    start_rem = rem_q;
    case (item_i.opcode)
      OP_SEND: begin
        if (state_q == ST_IDLE) begin
          res.accepted = 1'b1;
          if (item_i.phy_busy) begin
            rem_d   = load_c;
            pend_d  = item_i.dest_address;
            state_d = ST_CCABUSY;
          end else begin
            state_d       = ST_TX;
            res.send_now  = 1'b1;
            res.send_dest = item_i.dest_address;
          end
        end
      end
      OP_CHAN: begin
        if (item_i.channel_busy) begin
          if (state_q == ST_RUNNING) begin
            state_d = ST_CCABUSY;
          end
        end else if (state_q == ST_CCABUSY && !item_i.phy_cca_busy) begin
          start = 1'b1;
        end
      end
      OP_TICK: begin
        if (state_q == ST_RUNNING) begin
          rem_d     = rem_tick;
          start_rem = rem_tick;
          start     = 1'b1;
        end
      end
      OP_TXEND: begin
        if (state_q == ST_TX) begin
          state_d = ST_IDLE;
        end else if (state_q == ST_CCABUSY) begin
          start = item_i.phy_idle;
        end else begin
          res.bad_tx_end = 1'b1;
        end
      end
      OP_RXHDR: begin
        if (item_i.rx_dest == own_q || item_i.rx_dest == BCAST_ADDR) begin
          res.forward_up  = 1'b1;
          res.forward_src = item_i.rx_src;
        end
      end
      default: ;
    endcase

    // Resume the backoff; send straight away once it has run out
    if (start) begin
      state_d = ST_RUNNING;
      if (start_rem == '0) begin
        state_d       = ST_TX;
        res.send_now  = 1'b1;
        res.send_dest = pend_q;
      end
    end
    res.mac_state = state_code(state_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      pend_q  <= '0;
      own_q   <= OWN_ADDR_RST;
      cw_q    <= CW_RST;
      slot_q  <= SLOT_RST;
    end else begin
      if (adv_i) begin
        state_q <= state_d;
        rem_q   <= rem_d;
        pend_q  <= pend_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_ADDR: own_q  <= cfg_data_i[ADDR_W-1:0];
          CFG_CW:       cw_q   <= cfg_data_i[DRAW_W-1:0];
          CFG_SLOT:     slot_q <= cfg_data_i[SLOT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

>>> rtl/core/cbm_out_reg.sv
// Result register: packs and holds one result until the sink takes it.
`default_nettype none

module cbm_out_reg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire cbm_pkg::result_t               res_i,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [cbm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import cbm_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the payload while the transfer is stalled
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, res_q.bad_tx_end, res_q.mac_state, res_q.forward_src,
                          res_q.forward_up, res_q.send_dest, res_q.send_now,
                          res_q.accepted};

endmodule

`default_nettype wire

>>> rtl/core/csma_backoff_mac_controller.sv
// Top level of the CSMA MAC controller with freezing random backoff.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata event fields, tuser opcode
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields
//  cfg       in         cfg_we_i (no ready)            cfg_idx_i, cfg_data_i
//
// One event per cycle sustained while the sink accepts results; each event yields one result
// through the input register, then the result register (the backoff multiply and the state
// update are combinational between them).
// Reset puts the controller in idle with zero backoff and the registers at their
// defaults (own address 0, window 10, slot length 20).
// A stalled sink holds the result; one further event is taken into the input register.
`default_nettype none

module csma_backoff_mac_controller #(
  parameter int BACKOFF_BITS = cbm_pkg::BACKOFF_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // lowest bit up: dest_address[7:0], phy_busy, phy_cca_busy, phy_idle,
  // channel_busy, backoff_draw[9:0], rx_dest[7:0], rx_src[7:0], zero fill
  input  wire logic [cbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // opcode[2:0]
  input  wire logic [cbm_pkg::OPCODE_W-1:0]    s_axis_tuser,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lowest bit up: accepted, send_now, send_dest[7:0], forward_up,
  // forward_src[7:0], mac_state[1:0], bad_tx_end, zero fill
  output logic [cbm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            cfg_we_i,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import cbm_pkg::*;

  logic    item_vld;
  item_t   item;
  result_t res;
  logic    adv;

  // Advance when an event is held and the result register is free or being emptied
  assign adv = item_vld && (!m_axis_tvalid || m_axis_tready);

  cbm_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .adv_i         (adv),
    .item_vld_o    (item_vld),
    .item_o        (item)
  );

  cbm_core #(
    .BACKOFF_BITS (BACKOFF_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .item_i     (item),
    .res_o      (res)
  );

  cbm_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv),
    .res_i         (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The input side only stalls behind a full result register
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && item_vld))
    else $error("input stalled with room downstream");

  // A computed send always leaves the controller transmitting
  a_send_means_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res.send_now) |-> (res.mac_state == CODE_TX))
    else $error("send without transmit state");

  // A refused transmit end leaves idle or running untouched
  a_bad_end_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res.bad_tx_end) |-> (res.mac_state == CODE_IDLE || res.mac_state == CODE_RUNNING))
    else $error("bad transmit end in wrong state");

  // An accepted request that is not sent at once waits for the carrier
  a_deferred_to_cca: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res.accepted && !res.send_now) |=> (m_axis_tdata[20:19] == CODE_CCABUSY))
    else $error("deferred request not in carrier busy");

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the CSMA backoff MAC controller: directed events, then random traffic.
module tb;
  import cbm_pkg::*;

  localparam int BACKOFF_BITS = BACKOFF_BITS_DEF;
  localparam longint unsigned BACKOFF_MAX = (64'd1 << BACKOFF_BITS) - 64'd1;
  localparam int TICK_CAP = 200;
  localparam int RANDOM_ITEMS = 1500;
  localparam int NUM_PHASES = 8;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  // Shadow of the controller: predicts one result per event and checks arrivals in order.
  class mac_scoreboard;
    logic [ADDR_W-1:0]       own_addr;
    logic [DRAW_W-1:0]       window;
    logic [SLOT_W-1:0]       slot_len;
    logic [CODE_W-1:0]       mac_code;
    logic [BACKOFF_BITS-1:0] ticks_left;
    logic [ADDR_W-1:0]       held_dest;
    result_t                 due_results[$];
    int                      failures;

    function new();
      own_addr   = OWN_ADDR_RST;
      window     = CW_RST;
      slot_len   = SLOT_RST;
      mac_code   = CODE_IDLE;
      ticks_left = '0;
      held_dest  = '0;
      failures   = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_OWN_ADDR: own_addr = val[ADDR_W-1:0];
        CFG_CW:       window = val[DRAW_W-1:0];
        CFG_SLOT:     slot_len = val;
        default: ;
      endcase
    endfunction

    function longint unsigned backoff_for(input logic [DRAW_W-1:0] draw);
      longint unsigned slots;
      longint unsigned prod;
      if (window == '0) begin
        slots = 0;
      end else if (draw >= window) begin
        slots = 64'(window - 10'd1);
      end else begin
        slots = 64'(draw);
      end
      prod = slots * 64'(slot_len);
      return (prod > BACKOFF_MAX) ? BACKOFF_MAX : prod;
    endfunction

    // Enter the running state; transmit straight away when the count is spent.
    function void launch(inout result_t res);
      mac_code = CODE_RUNNING;
      if (ticks_left == '0) begin
        mac_code      = CODE_TX;
        res.send_now  = 1'b1;
        res.send_dest = held_dest;
      end
    endfunction

    function void take_event(input item_t ev);
      result_t res;
      res = '0;
      case (ev.opcode)
        OP_SEND: begin
          if (mac_code == CODE_IDLE) begin
            res.accepted = 1'b1;
            if (ev.phy_busy) begin
              ticks_left = BACKOFF_BITS'(backoff_for(ev.backoff_draw));
              held_dest  = ev.dest_address;
              mac_code   = CODE_CCABUSY;
            end else begin
              mac_code      = CODE_TX;
              res.send_now  = 1'b1;
              res.send_dest = ev.dest_address;
            end
          end
        end
        OP_CHAN: begin
          if (ev.channel_busy) begin
            if (mac_code == CODE_RUNNING) mac_code = CODE_CCABUSY;
          end else if (mac_code == CODE_CCABUSY && !ev.phy_cca_busy) begin
            launch(res);
          end
        end
        OP_TICK: begin
          if (mac_code == CODE_RUNNING) begin
            if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
            launch(res);
          end
        end
        OP_TXEND: begin
          if (mac_code == CODE_TX) begin
            mac_code = CODE_IDLE;
          end else if (mac_code == CODE_CCABUSY) begin
            if (ev.phy_idle) launch(res);
          end else begin
            res.bad_tx_end = 1'b1;
          end
        end
        OP_RXHDR: begin
          if (ev.rx_dest == own_addr || ev.rx_dest == BCAST_ADDR) begin
            res.forward_up  = 1'b1;
            res.forward_src = ev.rx_src;
          end
        end
        default: ;
      endcase
      res.mac_state = mac_code;
      due_results.push_back(res);
    endfunction

    function string describe(input result_t r);
      return $sformatf("acc=%0b send=%0b/%02h fwd=%0b/%02h state=%0d bad=%0b", r.accepted,
                       r.send_now, r.send_dest, r.forward_up, r.forward_src, r.mac_state,
                       r.bad_tx_end);
    endfunction

    function void log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void take_result(input result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        log_failure($sformatf("unexpected result %s", describe(got)));
        return;
      end
      want = due_results.pop_front();
      if (got.accepted !== want.accepted || got.send_now !== want.send_now ||
          got.send_dest !== want.send_dest || got.forward_up !== want.forward_up ||
          got.forward_src !== want.forward_src || got.mac_state !== want.mac_state ||
          got.bad_tx_end !== want.bad_tx_end)
        log_failure($sformatf("expected %s, got %s", describe(want), describe(got)));
    endfunction

    function void flag_leftovers();
      if (due_results.size() != 0)
        log_failure($sformatf("%0d results never arrived", due_results.size()));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OPCODE_W-1:0]   s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_OWN_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  mac_scoreboard sb;

  csma_backoff_mac_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted    = m_axis_tdata[0];
      got.send_now    = m_axis_tdata[1];
      got.send_dest   = m_axis_tdata[9:2];
      got.forward_up  = m_axis_tdata[10];
      got.forward_src = m_axis_tdata[18:11];
      got.mac_state   = m_axis_tdata[20:19];
      got.bad_tx_end  = m_axis_tdata[21];
      sb.take_result(got);
    end
  end

  function automatic item_t rand_item(input logic [OPCODE_W-1:0] op);
    item_t ev;
    ev.opcode       = op;
    ev.dest_address = ADDR_W'($urandom_range(255));
    ev.phy_busy     = 1'($urandom_range(1));
    ev.phy_cca_busy = 1'($urandom_range(1));
    ev.phy_idle     = 1'($urandom_range(1));
    ev.channel_busy = 1'($urandom_range(1));
    ev.backoff_draw = DRAW_W'($urandom_range(1023));
    ev.rx_dest      = ADDR_W'($urandom_range(255));
    ev.rx_src       = ADDR_W'($urandom_range(255));
    return ev;
  endfunction

  function automatic item_t header_item();
    item_t ev;
    int pick;
    ev   = rand_item(OP_RXHDR);
    pick = $urandom_range(9);
    if (pick < 4) ev.rx_dest = sb.own_addr;
    else if (pick < 7) ev.rx_dest = BCAST_ADDR;
    return ev;
  endfunction

  function automatic item_t noise_item();
    logic [OPCODE_W-1:0] op;
    if ($urandom_range(15) == 0) op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else op = OPCODE_W'($urandom_range(OP_SEND, OP_RXHDR));
    return (op == OP_RXHDR) ? header_item() : rand_item(op);
  endfunction

  task automatic push_event(input item_t ev);
    longint unsigned most;
    // Keep any backoff loaded from idle short enough to tick through.
    if (ev.opcode == OP_SEND && ev.phy_busy && sb.mac_code == CODE_IDLE &&
        sb.backoff_for(ev.backoff_draw) > TICK_CAP) begin
      most = 64'(TICK_CAP / sb.slot_len);
      ev.backoff_draw = DRAW_W'($urandom_range(0, int'((most > 1023) ? 1023 : most)));
    end
    if ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_gap_pct);
    end
    s_axis_tdata <= {2'b00, ev.rx_src, ev.rx_dest, ev.backoff_draw, ev.channel_busy,
                     ev.phy_idle, ev.phy_cca_busy, ev.phy_busy, ev.dest_address};
    s_axis_tuser  <= ev.opcode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_event(ev);
    if (ev.opcode <= OP_RXHDR) items_sent++;
  endtask

  // Hold the sender off until every predicted result has been transferred.
  task automatic wait_drained();
    int spin = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0 && spin < 100000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_setup(input logic [ADDR_W-1:0] own, input logic [DRAW_W-1:0] cw,
                             input logic [SLOT_W-1:0] slot);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] own_word;
    logic [CFG_DATA_W-1:0] cw_word;
    junk     = CFG_DATA_W'($urandom);
    own_word = {junk[15:8], own};
    cw_word  = {junk[15:10], cw};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OWN_ADDR;
    cfg_data_i <= own_word;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CW;
    cfg_data_i <= cw_word;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SLOT;
    cfg_data_i <= slot;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(CFG_OWN_ADDR, own_word);
    sb.set_reg(CFG_CW, cw_word);
    sb.set_reg(CFG_SLOT, slot);
  endtask

  // One packet from request to transmit end, with freezes and stray events mixed in.
  task automatic run_exchange();
    item_t ev;
    int roll;
    int guard = 0;
    if ($urandom_range(9) < 3) push_event(header_item());
    ev = rand_item(OP_SEND);
    ev.phy_busy = ($urandom_range(3) != 0);
    push_event(ev);
    while ((sb.mac_code == CODE_CCABUSY || sb.mac_code == CODE_RUNNING) && guard < 5000) begin
      roll = $urandom_range(99);
      guard++;
      if (sb.mac_code == CODE_CCABUSY) begin
        if (roll < 55) begin
          ev = rand_item(OP_CHAN);
          ev.channel_busy = 1'b0;
          ev.phy_cca_busy = ($urandom_range(5) == 0);
        end else if (roll < 70) begin
          ev = rand_item(OP_CHAN);
          ev.channel_busy = 1'b1;
        end else if (roll < 80) begin
          ev = rand_item(OP_TXEND);
        end else begin
          ev = noise_item();
        end
      end else begin
        if (roll < 85) begin
          ev = rand_item(OP_TICK);
        end else if (roll < 91) begin
          ev = rand_item(OP_CHAN);
          ev.channel_busy = 1'b1;
        end else if (roll < 94) begin
          ev = rand_item(OP_TXEND);
        end else begin
          ev = noise_item();
        end
      end
      push_event(ev);
    end
    if (sb.mac_code == CODE_TX && $urandom_range(9) < 3) push_event(noise_item());
    if (sb.mac_code == CODE_TX) push_event(rand_item(OP_TXEND));
  endtask

  initial begin
    item_t ev;
    int base;
    int phase_end;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events at the reset register values (own address 0).
    ev = rand_item(OP_RXHDR); ev.rx_dest = 8'h00; ev.rx_src = 8'hFF; push_event(ev);
    ev = rand_item(OP_RXHDR); ev.rx_dest = BCAST_ADDR; ev.rx_src = 8'h00; push_event(ev);
    ev = rand_item(OP_RXHDR); ev.rx_dest = 8'h7E; ev.rx_src = 8'h81; push_event(ev);
    ev = rand_item(OP_TXEND); push_event(ev);
    ev = rand_item(OP_SEND); ev.phy_busy = 1'b0; ev.dest_address = 8'hFF; push_event(ev);
    ev = rand_item(OP_SEND); push_event(ev);
    ev = rand_item(OP_TXEND); push_event(ev);
    ev = rand_item(OP_SEND); ev.phy_busy = 1'b1; ev.backoff_draw = '0;
    ev.dest_address = 8'h00; push_event(ev);
    ev = rand_item(OP_TXEND); ev.phy_idle = 1'b0; push_event(ev);
    ev = rand_item(OP_CHAN); ev.channel_busy = 1'b1; push_event(ev);
    ev = rand_item(OP_CHAN); ev.channel_busy = 1'b0; ev.phy_cca_busy = 1'b1; push_event(ev);
    ev = rand_item(OP_CHAN); ev.channel_busy = 1'b0; ev.phy_cca_busy = 1'b0; push_event(ev);
    ev = rand_item(OP_TXEND); push_event(ev);
    push_event(rand_item(OP_SPARE_HI));
    push_event(rand_item(OP_SPARE_LO));

    wait_drained();
    write_setup(8'h3C, 10'd3, 16'd1);
    // Oversized draw clamps to two slots; freeze once on the way down.
    ev = rand_item(OP_SEND); ev.phy_busy = 1'b1; ev.backoff_draw = 10'h3FF;
    ev.dest_address = 8'hA5; push_event(ev);
    ev = rand_item(OP_TXEND); ev.phy_idle = 1'b1; push_event(ev);
    push_event(rand_item(OP_TICK));
    ev = rand_item(OP_CHAN); ev.channel_busy = 1'b1; push_event(ev);
    push_event(rand_item(OP_TICK));
    ev = rand_item(OP_CHAN); ev.channel_busy = 1'b0; ev.phy_cca_busy = 1'b0; push_event(ev);
    push_event(rand_item(OP_TXEND));
    push_event(rand_item(OP_TICK));
    push_event(rand_item(OP_TXEND));
    ev = rand_item(OP_RXHDR); ev.rx_dest = 8'h3C; push_event(ev);

    base = items_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: write_setup(OWN_ADDR_RST, CW_RST, SLOT_RST);
        1: write_setup(8'hFF, 10'd0, 16'hFFFF);
        2: write_setup(ADDR_W'($urandom_range(255)), 10'd1, 16'd1);
        3: write_setup(ADDR_W'($urandom_range(255)), 10'd1023, 16'd1);
        4: write_setup(ADDR_W'($urandom_range(255)), 10'd5, 16'd3);
        5: write_setup(ADDR_W'($urandom_range(255)), 10'd12, 16'd2);
        6: write_setup(ADDR_W'($urandom_range(255)), 10'd1023, 16'hFFFF);
        default: write_setup(ADDR_W'($urandom_range(255)), 10'd7, 16'd1);
      endcase
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct <= 0;  end
        1: begin src_gap_pct = 75; sink_stall_pct <= 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct <= 75; end
        default: begin src_gap_pct = 9; sink_stall_pct <= 9; end
      endcase
      phase_end = base + (RANDOM_ITEMS * (p + 1)) / NUM_PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(49) == 0) wait_drained();
        if ($urandom_range(99) < 85) begin
          run_exchange();
        end else begin
          repeat ($urandom_range(1, 5)) push_event(noise_item());
        end
      end
    end

    wait_drained();
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_in_reg.sv
rtl/core/cbm_core.sv
rtl/core/cbm_out_reg.sv
rtl/core/csma_backoff_mac_controller.sv
verif/tb.sv
